// ===== rtl/cpu_8bit_execute_unit_assert.svh =====
// Assertion macros for the 8-bit execute unit, clocked on clk and disabled in rst.
`ifndef CPU_8BIT_EXECUTE_UNIT_ASSERT_SVH
`define CPU_8BIT_EXECUTE_UNIT_ASSERT_SVH

// prop must hold at every clock edge out of reset
`define CPU8EU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// cons must hold in the cycle after ante
`define CPU8EU_ASSERT_NEXT(name, ante, cons, msg) \
  `CPU8EU_ASSERT(name, (ante) |=> (cons), msg)

`endif

// ===== rtl/cpu8eu_pkg.sv =====
// Shared types and constants of the 8-bit execute unit.
package cpu8eu_pkg;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;

  // Operation codes, mnemonics in alphabetical order
  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
    OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
    OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BVC = 6'd10, OP_BVS = 6'd11,
    OP_CLC = 6'd12, OP_CLD = 6'd13, OP_CLI = 6'd14, OP_CLV = 6'd15,
    OP_CMP = 6'd16, OP_CPX = 6'd17, OP_CPY = 6'd18, OP_DEC = 6'd19,
    OP_DEX = 6'd20, OP_DEY = 6'd21, OP_EOR = 6'd22, OP_INC = 6'd23,
    OP_INX = 6'd24, OP_INY = 6'd25, OP_JMP = 6'd26, OP_LDA = 6'd27,
    OP_LDX = 6'd28, OP_LDY = 6'd29, OP_LSR = 6'd30, OP_NOP = 6'd31,
    OP_ORA = 6'd32, OP_ROL = 6'd33, OP_ROR = 6'd34, OP_SBC = 6'd35,
    OP_SEC = 6'd36, OP_SED = 6'd37, OP_SEI = 6'd38, OP_STA = 6'd39,
    OP_STX = 6'd40, OP_STY = 6'd41, OP_TAX = 6'd42, OP_TAY = 6'd43,
    OP_TSX = 6'd44, OP_TXA = 6'd45, OP_TXS = 6'd46, OP_TYA = 6'd47
  } func_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic       c;
    logic       z;
    logic       i;
    logic       d;
    logic       v;
    logic       n;
  } arch_t;

  typedef struct packed {
    logic [5:0]  func;
    logic [7:0]  operand;
    logic        to_memory;
    logic [15:0] instr_address;
    logic [15:0] jump_address;
  } item_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  status_out;
    logic [7:0]  write_data;
    logic        write_enable;
    logic        branch_taken;
    logic [15:0] branch_target;
  } result_t;

  // N V 1 0 D I Z C
  function automatic logic [7:0] pack_status(arch_t s);
    return {s.n, s.v, 1'b1, 1'b0, s.d, s.i, s.z, s.c};
  endfunction

endpackage

// ===== rtl/cpu8eu_alu.sv =====
// Register and flag update plus memory write for one decoded instruction.
module cpu8eu_alu import cpu8eu_pkg::*; (
  input  item_t      item,
  input  arch_t      st,
  output arch_t      st_next,
  output logic [7:0] write_data,
  output logic       write_enable
);

  logic [7:0] src;
  logic [7:0] add_b;
  logic [8:0] sum;
  logic [7:0] cmp_reg;
  logic [8:0] diff;
  logic [7:0] shl;
  logic [7:0] shr;
  logic [7:0] shv;
  logic       sh_c;
  func_t      op;

  function automatic logic [1:0] zn_of(logic [7:0] v);
    return {v[7], v == 8'd0};
  endfunction

  assign op    = func_t'(item.func);
  assign src   = item.to_memory ? item.operand : st.acc;
  // SBC is A + ~M + C on the same adder
  assign add_b = (op == OP_SBC) ? ~item.operand : item.operand;
  assign sum   = {1'b0, st.acc} + {1'b0, add_b} + {8'd0, st.c};

  assign cmp_reg = (op == OP_CPX) ? st.x : ((op == OP_CPY) ? st.y : st.acc);
  // carry out of reg + ~M + 1 is the no-borrow flag
  assign diff    = {1'b0, cmp_reg} + {1'b0, ~item.operand} + 9'd1;

  assign shl  = {src[6:0], (op == OP_ROL) ? st.c : 1'b0};
  assign shr  = {(op == OP_ROR) ? st.c : 1'b0, src[7:1]};
  assign shv  = (op == OP_ASL || op == OP_ROL) ? shl : shr;
  assign sh_c = (op == OP_ASL || op == OP_ROL) ? src[7] : src[0];

  always_comb begin
    st_next      = st;
    write_data   = 8'd0;
    write_enable = 1'b0;
    unique case (op)
      OP_ADC, OP_SBC: begin
        st_next.acc          = sum[7:0];
        st_next.c            = sum[8];
        st_next.v            = (st.acc[7] ^ sum[7]) & (add_b[7] ^ sum[7]);
        {st_next.n, st_next.z} = zn_of(sum[7:0]);
      end
      OP_AND: begin
        st_next.acc          = st.acc & item.operand;
        {st_next.n, st_next.z} = zn_of(st.acc & item.operand);
      end
      OP_EOR: begin
        st_next.acc          = st.acc ^ item.operand;
        {st_next.n, st_next.z} = zn_of(st.acc ^ item.operand);
      end
      OP_ORA: begin
        st_next.acc          = st.acc | item.operand;
        {st_next.n, st_next.z} = zn_of(st.acc | item.operand);
      end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        st_next.c            = sh_c;
        {st_next.n, st_next.z} = zn_of(shv);
        if (item.to_memory) begin
          write_data   = shv;
          write_enable = 1'b1;
        end else begin
          st_next.acc = shv;
        end
      end
      OP_BIT: begin
        st_next.z = (st.acc & item.operand) == 8'd0;
        st_next.v = item.operand[6];
        st_next.n = item.operand[7];
      end
      OP_CLC: st_next.c = 1'b0;
      OP_CLD: st_next.d = 1'b0;
      OP_CLI: st_next.i = 1'b0;
      OP_CLV: st_next.v = 1'b0;
      OP_SEC: st_next.c = 1'b1;
      OP_SED: st_next.d = 1'b1;
      OP_SEI: st_next.i = 1'b1;
      OP_CMP, OP_CPX, OP_CPY: begin
        st_next.c = diff[8];
        st_next.z = cmp_reg == item.operand;
        st_next.n = diff[7];
      end
      OP_DEC: begin
        write_data           = item.operand - 8'd1;
        write_enable         = 1'b1;
        {st_next.n, st_next.z} = zn_of(item.operand - 8'd1);
      end
      OP_INC: begin
        write_data           = item.operand + 8'd1;
        write_enable         = 1'b1;
        {st_next.n, st_next.z} = zn_of(item.operand + 8'd1);
      end
      OP_DEX: begin
        st_next.x            = st.x - 8'd1;
        {st_next.n, st_next.z} = zn_of(st.x - 8'd1);
      end
      OP_DEY: begin
        st_next.y            = st.y - 8'd1;
        {st_next.n, st_next.z} = zn_of(st.y - 8'd1);
      end
      OP_INX: begin
        st_next.x            = st.x + 8'd1;
        {st_next.n, st_next.z} = zn_of(st.x + 8'd1);
      end
      OP_INY: begin
        st_next.y            = st.y + 8'd1;
        {st_next.n, st_next.z} = zn_of(st.y + 8'd1);
      end
      OP_LDA: begin
        st_next.acc          = item.operand;
        {st_next.n, st_next.z} = zn_of(item.operand);
      end
      OP_LDX: begin
        st_next.x            = item.operand;
        {st_next.n, st_next.z} = zn_of(item.operand);
      end
      OP_LDY: begin
        st_next.y            = item.operand;
        {st_next.n, st_next.z} = zn_of(item.operand);
      end
      OP_STA: begin
        write_data   = st.acc;
        write_enable = 1'b1;
      end
      OP_STX: begin
        write_data   = st.x;
        write_enable = 1'b1;
      end
      OP_STY: begin
        write_data   = st.y;
        write_enable = 1'b1;
      end
      OP_TAX: begin
        st_next.x            = st.acc;
        {st_next.n, st_next.z} = zn_of(st.acc);
      end
      OP_TAY: begin
        st_next.y            = st.acc;
        {st_next.n, st_next.z} = zn_of(st.acc);
      end
      OP_TSX: begin
        st_next.x            = st.sp;
        {st_next.n, st_next.z} = zn_of(st.sp);
      end
      OP_TXA: begin
        st_next.acc          = st.x;
        {st_next.n, st_next.z} = zn_of(st.x);
      end
      OP_TYA: begin
        st_next.acc          = st.y;
        {st_next.n, st_next.z} = zn_of(st.y);
      end
      OP_TXS: st_next.sp = st.x;
      // branches, jump, NOP and unassigned codes leave the state alone
      default: ;
    endcase
  end

endmodule

// ===== rtl/cpu8eu_branch.sv =====
// Branch condition evaluation and target address for one decoded instruction.
module cpu8eu_branch import cpu8eu_pkg::*; (
  input  item_t       item,
  input  arch_t       st,
  output logic        branch_taken,
  output logic [15:0] branch_target
);

  logic  cond;
  logic  [15:0] rel_target;
  func_t op;

  assign op = func_t'(item.func);
  assign rel_target = item.instr_address + 16'd2 + {{8{item.operand[7]}}, item.operand};

  always_comb begin
    cond = 1'b0;
    unique case (op)
      OP_BCC:  cond = !st.c;
      OP_BCS:  cond = st.c;
      OP_BEQ:  cond = st.z;
      OP_BNE:  cond = !st.z;
      OP_BMI:  cond = st.n;
      OP_BPL:  cond = !st.n;
      OP_BVC:  cond = !st.v;
      OP_BVS:  cond = st.v;
      default: cond = 1'b0;
    endcase
  end

  always_comb begin
    branch_taken  = 1'b0;
    branch_target = 16'd0;
    if (op == OP_JMP) begin
      branch_taken  = 1'b1;
      branch_target = item.jump_address;
    end else if (cond) begin
      branch_taken  = 1'b1;
      branch_target = rel_target;
    end
  end

endmodule

// ===== rtl/cpu_8bit_execute_unit.sv =====
// Top level of the 8-bit execute unit: request registers, state and result register.
//
// Executes one decoded 6502-style instruction per request against the A, X, Y, SP
// registers and the C Z I D V N flags (binary arithmetic only). A request is taken
// into an input register, executed in a single combinational pass (ADC/SBC and
// compare adders, logic and shift, flag update, branch adder) and written to the
// result register together with the new register state. Throughput is one
// request per cycle while the result is not stalled. The state commits as the
// request leaves the input register for the result register, so each request
// sees the effects of the one before it.
// s_tready drops only while both the input and result registers are full and the
// result is stalled.
`include "cpu_8bit_execute_unit_assert.svh"

module cpu_8bit_execute_unit import cpu8eu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // func[5:0], operand[13:6], to_memory[14], instr_address[30:15],
  // jump_address[46:31], zero pad[47]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // acc_out[7:0], x_out[15:8], y_out[23:16], status_out[31:24], write_data[39:32],
  // write_enable[40], branch_taken[41], branch_target[57:42], zero pad[63:58]
  output logic [OUT_DATA_W-1:0] m_tdata
);

  item_t       in_item;
  item_t       s1_item;
  logic        s1_valid;
  logic        out_load;
  logic        s1_fire;
  arch_t       arch;
  arch_t       arch_next;
  result_t     res_next;
  result_t     res;
  logic [7:0]  wdata;
  logic        wen;
  logic        taken;
  logic [15:0] target;

  assign in_item.func          = s_tdata[5:0];
  assign in_item.operand       = s_tdata[13:6];
  assign in_item.to_memory     = s_tdata[14];
  assign in_item.instr_address = s_tdata[30:15];
  assign in_item.jump_address  = s_tdata[46:31];

  assign out_load = !m_tvalid || m_tready;
  assign s1_fire  = s1_valid && out_load;
  assign s_tready = !s1_valid || out_load;

  cpu8eu_alu u_alu (
    .item         (s1_item),
    .st           (arch),
    .st_next      (arch_next),
    .write_data   (wdata),
    .write_enable (wen)
  );

  cpu8eu_branch u_branch (
    .item          (s1_item),
    .st            (arch),
    .branch_taken  (taken),
    .branch_target (target)
  );

  assign res_next.acc_out       = arch_next.acc;
  assign res_next.x_out         = arch_next.x;
  assign res_next.y_out         = arch_next.y;
  assign res_next.status_out    = pack_status(arch_next);
  assign res_next.write_data    = wdata;
  assign res_next.write_enable  = wen;
  assign res_next.branch_taken  = taken;
  assign res_next.branch_target = target;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
      arch     <= '0;
    end else begin
      if (s_tready) s1_valid <= s_tvalid;
      if (out_load) m_tvalid <= s1_valid;
      if (s1_fire)  arch     <= arch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) s1_item <= in_item;
    if (s1_fire)              res     <= res_next;
  end

  assign m_tdata = {6'd0, res.branch_target, res.branch_taken, res.write_enable,
                    res.write_data, res.status_out, res.y_out, res.x_out, res.acc_out};

  `CPU8EU_ASSERT(a_wdata_zero,
    !m_tvalid || res.write_enable || res.write_data == 8'd0, "write data without strobe")
  `CPU8EU_ASSERT(a_target_zero,
    !m_tvalid || res.branch_taken || res.branch_target == 16'd0, "target without branch")
  `CPU8EU_ASSERT_NEXT(a_state_hold, !s1_fire, $stable(arch),
    "state changed with no request executed")
  `CPU8EU_ASSERT_NEXT(a_sp_txs, !(s1_fire && s1_item.func == OP_TXS), $stable(arch.sp),
    "stack pointer changed outside TXS")

endmodule
